### sv/lip_pkg.sv
package lip_pkg;

  localparam int FracBits = 16;
  localparam int CoordW   = 32;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int SumW     = ProdW + 1;
  localparam int MagW     = SumW;
  localparam int QuoW     = 32;
  localparam int RemW     = MagW + QuoW;
  localparam int InDataW  = 8 * CoordW;
  localparam int OutDataW = 72;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [MagW-1:0] den;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            big;
  } lane_t;

  function automatic lane_t div_step(lane_t l);
    logic [RemW:0]   diff;
    logic [RemW-1:0] r;
    lane_t           o;
    diff = {1'b0, l.rem} - {2'b00, l.den, {(QuoW-1){1'b0}}};
    r    = diff[RemW] ? l.rem : diff[RemW-1:0];
    o     = l;
    o.rem = {r[RemW-2:0], 1'b0};
    o.quo = {l.quo[QuoW-2:0], ~diff[RemW]};
    return o;
  endfunction

endpackage

### sv/lip_cross.sv
module lip_cross (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [lip_pkg::InDataW-1:0]        data_i,
  output logic                               valid_o,
  output logic signed [lip_pkg::SumW-1:0]    h_o,
  output logic signed [lip_pkg::SumW-1:0]    n1_o,
  output logic signed [lip_pkg::SumW-1:0]    n2_o
);
  import lip_pkg::*;

  logic signed [CoordW-1:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
  logic signed [DiffW-1:0]  da_q, db_q, dc_q, de_q, df_q, dg_q, dx_q, dy_q;
  logic signed [ProdW-1:0]  p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic                     v1_q, v2_q, v3_q;

  assign s1x = data_i[0*CoordW +: CoordW];
  assign s1y = data_i[1*CoordW +: CoordW];
  assign e1x = data_i[2*CoordW +: CoordW];
  assign e1y = data_i[3*CoordW +: CoordW];
  assign s2x = data_i[4*CoordW +: CoordW];
  assign s2y = data_i[5*CoordW +: CoordW];
  assign e2x = data_i[6*CoordW +: CoordW];
  assign e2y = data_i[7*CoordW +: CoordW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      da_q <= DiffW'(e2x) - DiffW'(s2x);
      db_q <= DiffW'(s1y) - DiffW'(e1y);
      dc_q <= DiffW'(s1x) - DiffW'(e1x);
      de_q <= DiffW'(e2y) - DiffW'(s2y);
      df_q <= DiffW'(s2y) - DiffW'(e2y);
      dg_q <= DiffW'(e1x) - DiffW'(s1x);
      dx_q <= DiffW'(s1x) - DiffW'(s2x);
      dy_q <= DiffW'(s1y) - DiffW'(s2y);
      p0_q <= da_q * db_q;
      p1_q <= dc_q * de_q;
      p2_q <= df_q * dx_q;
      p3_q <= da_q * dy_q;
      p4_q <= db_q * dx_q;
      p5_q <= dg_q * dy_q;
      h_o  <= {p0_q[ProdW-1], p0_q} - {p1_q[ProdW-1], p1_q};
      n1_o <= {p2_q[ProdW-1], p2_q} + {p3_q[ProdW-1], p3_q};
      n2_o <= {p4_q[ProdW-1], p4_q} + {p5_q[ProdW-1], p5_q};
    end
  end

  assign valid_o = v3_q;

endmodule

### sv/lip_prep.sv
module lip_prep (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [lip_pkg::SumW-1:0] h_i,
  input  logic signed [lip_pkg::SumW-1:0] n1_i,
  input  logic signed [lip_pkg::SumW-1:0] n2_i,
  output logic                            valid_o,
  output logic                            par_o,
  output lip_pkg::lane_t                  lane1_o,
  output lip_pkg::lane_t                  lane2_o
);
  import lip_pkg::*;

  logic [MagW-1:0] hmag, n1mag, n2mag;
  logic            v4_q, v5_q, par4_q, par5_q;
  lane_t           l1_q, l2_q;

  assign hmag  = h_i[SumW-1]  ? MagW'(-h_i)  : MagW'(h_i);
  assign n1mag = n1_i[SumW-1] ? MagW'(-n1_i) : MagW'(n1_i);
  assign n2mag = n2_i[SumW-1] ? MagW'(-n2_i) : MagW'(n2_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      par4_q   <= (h_i == '0);
      l1_q.rem <= RemW'({n1mag, {FracBits{1'b0}}});
      l1_q.den <= hmag;
      l1_q.quo <= '0;
      l1_q.neg <= n1_i[SumW-1] ^ h_i[SumW-1];
      l1_q.big <= 1'b0;
      l2_q.rem <= RemW'({n2mag, {FracBits{1'b0}}});
      l2_q.den <= hmag;
      l2_q.quo <= '0;
      l2_q.neg <= n2_i[SumW-1] ^ h_i[SumW-1];
      l2_q.big <= 1'b0;
      par5_q   <= par4_q;
      lane1_o.rem <= l1_q.rem;
      lane1_o.den <= l1_q.den;
      lane1_o.quo <= l1_q.quo;
      lane1_o.neg <= l1_q.neg;
      lane1_o.big <= (l1_q.rem >= {l1_q.den, {QuoW{1'b0}}});
      lane2_o.rem <= l2_q.rem;
      lane2_o.den <= l2_q.den;
      lane2_o.quo <= l2_q.quo;
      lane2_o.neg <= l2_q.neg;
      lane2_o.big <= (l2_q.rem >= {l2_q.den, {QuoW{1'b0}}});
    end
  end

  assign valid_o = v5_q;
  assign par_o   = par5_q;

endmodule

### sv/lip_divstep.sv
module lip_divstep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic           par_i,
  input  lip_pkg::lane_t lane1_i,
  input  lip_pkg::lane_t lane2_i,
  output logic           valid_o,
  output logic           par_o,
  output lip_pkg::lane_t lane1_o,
  output lip_pkg::lane_t lane2_o
);
  import lip_pkg::*;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      par_o   <= par_i;
      lane1_o <= div_step(lane1_i);
      lane2_o <= div_step(lane2_i);
    end
  end

endmodule

### sv/line_intersection_params.sv
// Line intersection parameters.
// Slave channel s_axis: one transfer carries two lines (start and end points,
// signed Q16.16). Master channel m_axis: one transfer per input transfer with
// the crossing parameters t1, t2 (Q16.16, saturated), a parallel flag and a
// saturation flag.
// Pipeline: three stages form differences, 33x33 products and the
// determinant and numerators, two stages take magnitudes and check for
// quotient overflow, 32 restoring divider stages produce one quotient bit
// each for both parameters, and one stage applies sign and saturation into
// the output register. Throughput: one transfer per cycle unless m_axis
// stalls; both divisions run in parallel lanes.
// Reset clears all valid bits; the pipeline is empty and s_axis_tready_o is
// high after reset.
// A stall on m_axis freezes the whole pipeline in place; s_axis_tready_o drops
// only while the output register holds a result that is not taken, so no
// item is lost or repeated.
module line_intersection_params (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // line1_start_x, line1_start_y, line1_end_x, line1_end_y,
  // line2_start_x, line2_start_y, line2_end_x, line2_end_y
  input  logic [lip_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // param_one, param_two, parallel, saturated, zero fill
  output logic [lip_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import lip_pkg::*;

  localparam int Steps = QuoW;

  logic                    en;
  logic                    cv;
  logic signed [SumW-1:0]  h, n1, n2;
  logic                    sv_valid [Steps+1];
  logic                    sv_par   [Steps+1];
  lane_t                   sv_l1    [Steps+1];
  lane_t                   sv_l2    [Steps+1];
  logic                    out_valid_q;
  logic [QuoW-1:0]         t1_d, t2_d, t1_q, t2_q;
  logic                    s1_d, s2_d;
  logic                    par_q, sat_q;

  assign en = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  lip_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .data_i  (s_axis_tdata_i),
    .valid_o (cv),
    .h_o     (h),
    .n1_o    (n1),
    .n2_o    (n2)
  );

  lip_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv),
    .h_i     (h),
    .n1_i    (n1),
    .n2_i    (n2),
    .valid_o (sv_valid[0]),
    .par_o   (sv_par[0]),
    .lane1_o (sv_l1[0]),
    .lane2_o (sv_l2[0])
  );

  for (genvar i = 0; i < Steps; i++) begin : g_step
    lip_divstep u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv_valid[i]),
      .par_i   (sv_par[i]),
      .lane1_i (sv_l1[i]),
      .lane2_i (sv_l2[i]),
      .valid_o (sv_valid[i+1]),
      .par_o   (sv_par[i+1]),
      .lane1_o (sv_l1[i+1]),
      .lane2_o (sv_l2[i+1])
    );
  end

  always_comb begin
    t1_d = '0;
    s1_d = 1'b0;
    if (sv_l1[Steps].neg) begin
      if (sv_l1[Steps].big || sv_l1[Steps].quo > {1'b1, {(QuoW-1){1'b0}}}) begin
        t1_d = {1'b1, {(QuoW-1){1'b0}}};
        s1_d = 1'b1;
      end else begin
        t1_d = -sv_l1[Steps].quo;
      end
    end else if (sv_l1[Steps].big || sv_l1[Steps].quo[QuoW-1]) begin
      t1_d = {1'b0, {(QuoW-1){1'b1}}};
      s1_d = 1'b1;
    end else begin
      t1_d = sv_l1[Steps].quo;
    end
    t2_d = '0;
    s2_d = 1'b0;
    if (sv_l2[Steps].neg) begin
      if (sv_l2[Steps].big || sv_l2[Steps].quo > {1'b1, {(QuoW-1){1'b0}}}) begin
        t2_d = {1'b1, {(QuoW-1){1'b0}}};
        s2_d = 1'b1;
      end else begin
        t2_d = -sv_l2[Steps].quo;
      end
    end else if (sv_l2[Steps].big || sv_l2[Steps].quo[QuoW-1]) begin
      t2_d = {1'b0, {(QuoW-1){1'b1}}};
      s2_d = 1'b1;
    end else begin
      t2_d = sv_l2[Steps].quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sv_valid[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      par_q <= sv_par[Steps];
      if (sv_par[Steps]) begin
        t1_q  <= '0;
        t2_q  <= '0;
        sat_q <= 1'b0;
      end else begin
        t1_q  <= t1_d;
        t2_q  <= t2_d;
        sat_q <= s1_d || s2_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-2*QuoW-2){1'b0}}, sat_q, par_q, t2_q, t1_q};

endmodule
